/* sv/sac_pkg.sv */
`default_nettype none

package sac_pkg;

   // Identity byte returned by the read-ID command.
   localparam logic [7:0] CHIP_ID = 8'h08;

   // Command bytes.
   localparam logic [7:0] CMD_READ_ID     = 8'h60;
   localparam logic [7:0] CMD_READ_MODE   = 8'h48;
   localparam logic [7:0] CMD_WRITE_MODE  = 8'h08;
   localparam logic [7:0] CMD_READ_STATUS = 8'h40;
   localparam logic [7:0] CMD_READ_DATA   = 8'h58;
   localparam logic [7:0] CMD_READ_CONT   = 8'h5C;
   localparam logic [7:0] CMD_NOP         = 8'hFF;

   localparam logic [31:0] HISTORY_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [15:0] MODE_RESET       = 16'h000A;
   localparam int unsigned MODE_SHIFT       = 13;

   localparam logic [23:0] STARTUP_DELAY_RESET = 24'd120760;
   localparam logic [23:0] CONV_PERIOD_RESET   = 24'd59880;

   // Conversion modes held in bits 15:13 of the mode word.
   localparam logic [2:0] MODE_CONTINUOUS = 3'd0;
   localparam logic [2:0] MODE_SINGLE     = 3'd1;
   localparam logic [2:0] MODE_IDLE       = 3'd2;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_CMD  = 2'd1,
      ERR_BAD_MODE = 2'd2
   } error_type;

   typedef enum logic [0:0] {
      CSR_STARTUP_DELAY = 1'b0,
      CSR_CONV_PERIOD   = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

/* sv/sac_ifs.sv */
`default_nettype none

interface sac_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  mosi_byte;
   logic [15:0] sample_value;

   modport source (output valid, output req_type, output mosi_byte,
                   output sample_value, input ready);
   modport sink   (input valid, input req_type, input mosi_byte,
                   input sample_value, output ready);
endinterface

interface sac_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] miso_byte;
   logic       miso_valid;
   logic       ready_n;
   logic       conversion_done;
   logic       reset_seen;
   logic [1:0] error_code;

   modport source (output valid, output miso_byte, output miso_valid, output ready_n,
                   output conversion_done, output reset_seen, output error_code,
                   input ready);
   modport sink   (input valid, input miso_byte, input miso_valid, input ready_n,
                   input conversion_done, input reset_seen, input error_code,
                   output ready);
endinterface

interface sac_csr_if;
   logic                   valid;
   logic                   ready;
   sac_pkg::csr_index_type index;
   logic [23:0]            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/spi_adc_command_interface.sv */
// Slave-side command decoder of a serial converter interface.
// The req_ch channel carries one item per transfer: either a serial byte that the
// master exchanged (req_type 0, mosi_byte) or one time tick with the converter's
// next sample (req_type 1, sample_value). For every accepted transfer exactly one
// result leaves on rsp_ch: the byte to drive back, the ready line level, and flags
// for a latched conversion, a thirty-two-ones register reset and decode errors.
// The csr_ch channel writes the start-up delay and the conversion period; it is
// always ready and should only be used while the block is idle.
// The result of an item accepted at one edge is registered at that edge and valid
// after it. Throughput is one item per cycle while rsp_ch is not stalled, set by the
// single decode stage between the input handshake and the result register.
// When the receiver stalls, the result register holds its value, and a new item
// is still accepted in the cycle the held result is taken. While a result waits
// with rsp_ch.ready low, req_ch.ready is low.
// Reset is synchronous: it clears the command state, restores the mode word,
// status and configuration defaults and empties the result register.
`default_nettype none

module spi_adc_command_interface (
   input  wire logic  clock,
   input  wire logic  reset,
   sac_req_if.sink    req_ch,
   sac_rsp_if.source  rsp_ch,
   sac_csr_if.sink    csr_ch
);

   typedef enum logic [2:0] {
      PH_COMMAND     = 3'd0,
      PH_MODE_HI     = 3'd1,
      PH_MODE_LO     = 3'd2,
      PH_CONT_FIRST  = 3'd3,
      PH_CONT_SECOND = 3'd4
   } phase_type;

   // Configuration registers.
   logic [23:0] startup_delay_ff;
   logic [23:0] conv_period_ff;

   // Command and conversion state. Only bit 7 of the status word ever changes,
   // so it is held as the single ready flag (1 means not ready).
   logic        rdy_ff, rdy_in;
   logic [15:0] mode_word_ff, mode_word_in;
   logic [15:0] data_word_ff, data_word_in;
   logic [31:0] history_ff, history_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] tx_queue_ff, tx_queue_in;
   logic [1:0]  tx_left_ff, tx_left_in;
   logic [7:0]  mode_high_ff, mode_high_in;
   logic [23:0] start_count_ff, start_count_in;
   logic        start_pending_ff, start_pending_in;
   logic [2:0]  pending_mode_ff, pending_mode_in;
   logic        continuous_ff, continuous_in;
   logic [23:0] period_count_ff, period_count_in;
   logic [7:0]  pair_first_ff, pair_first_in;
   logic [7:0]  pair_low_ff, pair_low_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         miso_byte_ff, miso_byte_in;
   logic               miso_valid_ff, miso_valid_in;
   logic               done_ff, done_in;
   logic               reset_seen_ff, reset_seen_in;
   sac_pkg::error_type error_ff, error_in;

   logic req_accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.miso_byte       = miso_byte_ff;
   assign rsp_ch.miso_valid      = miso_valid_ff;
   assign rsp_ch.ready_n         = rdy_ff;
   assign rsp_ch.conversion_done = done_ff;
   assign rsp_ch.reset_seen      = reset_seen_ff;
   assign rsp_ch.error_code      = error_ff;

   always_comb begin
      logic        fired;
      logic [31:0] hist_first;
      logic [31:0] hist_both;
      logic [15:0] new_mode;

      rdy_in           = rdy_ff;
      mode_word_in     = mode_word_ff;
      data_word_in     = data_word_ff;
      history_in       = history_ff;
      phase_in         = phase_ff;
      tx_queue_in      = tx_queue_ff;
      tx_left_in       = tx_left_ff;
      mode_high_in     = mode_high_ff;
      start_count_in   = start_count_ff;
      start_pending_in = start_pending_ff;
      pending_mode_in  = pending_mode_ff;
      continuous_in    = continuous_ff;
      period_count_in  = period_count_ff;
      pair_first_in    = pair_first_ff;
      pair_low_in      = pair_low_ff;

      miso_byte_in  = 8'h00;
      miso_valid_in = 1'b0;
      done_in       = 1'b0;
      reset_seen_in = 1'b0;
      error_in      = sac_pkg::ERR_NONE;

      fired      = 1'b0;
      hist_first = {history_ff[23:0], pair_first_ff};
      hist_both  = {history_ff[15:0], pair_first_ff, req_ch.mosi_byte};
      new_mode   = {mode_high_ff, req_ch.mosi_byte};

      if (req_accept) begin
         if (req_ch.req_type) begin
            // Time tick: the delayed start has priority over periodic conversion.
            if (start_pending_ff) begin
               if (start_count_ff <= 24'd1) begin
                  fired            = 1'b1;
                  start_pending_in = 1'b0;
                  start_count_in   = 24'd0;
                  case (pending_mode_ff)
                     sac_pkg::MODE_CONTINUOUS: begin
                        data_word_in    = req_ch.sample_value;
                        rdy_in          = 1'b0;
                        done_in         = 1'b1;
                        continuous_in   = 1'b1;
                        period_count_in = conv_period_ff;
                     end
                     sac_pkg::MODE_SINGLE: begin
                        continuous_in   = 1'b0;
                        period_count_in = 24'd0;
                        data_word_in    = req_ch.sample_value;
                        rdy_in          = 1'b0;
                        done_in         = 1'b1;
                     end
                     sac_pkg::MODE_IDLE: begin
                        rdy_in          = 1'b1;
                        mode_word_in    = sac_pkg::MODE_RESET;
                        data_word_in    = 16'h0000;
                        continuous_in   = 1'b0;
                        period_count_in = 24'd0;
                        history_in      = 32'h0;
                     end
                     default: begin
                        error_in = sac_pkg::ERR_BAD_MODE;
                     end
                  endcase
               end else begin
                  start_count_in = start_count_ff - 24'd1;
               end
            end
            if (!fired && continuous_ff) begin
               if (period_count_ff <= 24'd1) begin
                  data_word_in    = req_ch.sample_value;
                  rdy_in          = 1'b0;
                  done_in         = 1'b1;
                  period_count_in = conv_period_ff;
               end else begin
                  period_count_in = period_count_ff - 24'd1;
               end
            end
         end else if (tx_left_ff != 2'd0) begin
            // Response byte in flight: the received byte is a dummy.
            miso_byte_in  = tx_queue_ff[15:8];
            miso_valid_in = 1'b1;
            tx_queue_in   = {tx_queue_ff[7:0], 8'h00};
            tx_left_in    = tx_left_ff - 2'd1;
         end else begin
            case (phase_ff)
               PH_MODE_HI: begin
                  mode_high_in = req_ch.mosi_byte;
                  phase_in     = PH_MODE_LO;
               end
               PH_MODE_LO: begin
                  mode_word_in     = new_mode;
                  pending_mode_in  = new_mode[sac_pkg::MODE_SHIFT +: 3];
                  start_pending_in = 1'b1;
                  start_count_in   = startup_delay_ff;
                  phase_in         = PH_COMMAND;
               end
               PH_CONT_FIRST: begin
                  miso_byte_in  = data_word_ff[15:8];
                  miso_valid_in = 1'b1;
                  pair_low_in   = data_word_ff[7:0];
                  pair_first_in = req_ch.mosi_byte;
                  phase_in      = PH_CONT_SECOND;
               end
               PH_CONT_SECOND: begin
                  miso_byte_in  = pair_low_ff;
                  miso_valid_in = 1'b1;
                  rdy_in        = 1'b1;
                  phase_in      = PH_CONT_FIRST;
                  if (pair_first_ff == sac_pkg::CMD_READ_DATA ||
                      req_ch.mosi_byte == sac_pkg::CMD_READ_DATA) begin
                     phase_in = PH_COMMAND;
                  end else if (hist_first == sac_pkg::HISTORY_ALL_ONES ||
                               hist_both == sac_pkg::HISTORY_ALL_ONES) begin
                     // Either byte completing the ones pattern resets the registers.
                     mode_word_in    = sac_pkg::MODE_RESET;
                     data_word_in    = 16'h0000;
                     continuous_in   = 1'b0;
                     period_count_in = 24'd0;
                     history_in      = 32'h0;
                     reset_seen_in   = 1'b1;
                     phase_in        = PH_COMMAND;
                  end else begin
                     history_in = hist_both;
                  end
               end
               default: begin
                  // Command byte. A history of all ones can only end in the no-op
                  // byte, so the reset never meets another command.
                  history_in = {history_ff[23:0], req_ch.mosi_byte};
                  if ({history_ff[23:0], req_ch.mosi_byte} == sac_pkg::HISTORY_ALL_ONES)
                  begin
                     rdy_in          = 1'b1;
                     mode_word_in    = sac_pkg::MODE_RESET;
                     data_word_in    = 16'h0000;
                     continuous_in   = 1'b0;
                     period_count_in = 24'd0;
                     history_in      = 32'h0;
                     reset_seen_in   = 1'b1;
                     phase_in        = PH_COMMAND;
                  end
                  case (req_ch.mosi_byte)
                     sac_pkg::CMD_READ_ID: begin
                        tx_queue_in = {sac_pkg::CHIP_ID, 8'h00};
                        tx_left_in  = 2'd1;
                     end
                     sac_pkg::CMD_READ_MODE: begin
                        tx_queue_in = mode_word_ff;
                        tx_left_in  = 2'd2;
                     end
                     sac_pkg::CMD_WRITE_MODE: begin
                        phase_in = PH_MODE_HI;
                     end
                     sac_pkg::CMD_READ_STATUS: begin
                        tx_queue_in = {rdy_ff, 15'h0000};
                        tx_left_in  = 2'd1;
                     end
                     sac_pkg::CMD_READ_DATA: begin
                        if (!rdy_ff) begin
                           tx_queue_in = data_word_ff;
                           tx_left_in  = 2'd2;
                           rdy_in      = 1'b1;
                        end
                     end
                     sac_pkg::CMD_READ_CONT: begin
                        rdy_in   = 1'b1;
                        phase_in = PH_CONT_FIRST;
                     end
                     sac_pkg::CMD_NOP: begin
                        error_in = sac_pkg::ERR_NONE;
                     end
                     default: begin
                        error_in = sac_pkg::ERR_BAD_CMD;
                     end
                  endcase
               end
            endcase
         end
      end

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_delay_ff <= sac_pkg::STARTUP_DELAY_RESET;
         conv_period_ff   <= sac_pkg::CONV_PERIOD_RESET;
         rdy_ff           <= 1'b1;
         mode_word_ff     <= sac_pkg::MODE_RESET;
         data_word_ff     <= 16'h0000;
         history_ff       <= 32'h0;
         phase_ff         <= PH_COMMAND;
         tx_queue_ff      <= 16'h0000;
         tx_left_ff       <= 2'd0;
         mode_high_ff     <= 8'h00;
         start_count_ff   <= 24'd0;
         start_pending_ff <= 1'b0;
         pending_mode_ff  <= 3'd0;
         continuous_ff    <= 1'b0;
         period_count_ff  <= 24'd0;
         pair_first_ff    <= 8'h00;
         pair_low_ff      <= 8'h00;
         rsp_valid_ff     <= 1'b0;
         miso_byte_ff     <= 8'h00;
         miso_valid_ff    <= 1'b0;
         done_ff          <= 1'b0;
         reset_seen_ff    <= 1'b0;
         error_ff         <= sac_pkg::ERR_NONE;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               sac_pkg::CSR_STARTUP_DELAY: startup_delay_ff <= csr_ch.data;
               sac_pkg::CSR_CONV_PERIOD:   conv_period_ff   <= csr_ch.data;
               default: begin
                  startup_delay_ff <= startup_delay_ff;
               end
            endcase
         end
         rdy_ff           <= rdy_in;
         mode_word_ff     <= mode_word_in;
         data_word_ff     <= data_word_in;
         history_ff       <= history_in;
         phase_ff         <= phase_in;
         tx_queue_ff      <= tx_queue_in;
         tx_left_ff       <= tx_left_in;
         mode_high_ff     <= mode_high_in;
         start_count_ff   <= start_count_in;
         start_pending_ff <= start_pending_in;
         pending_mode_ff  <= pending_mode_in;
         continuous_ff    <= continuous_in;
         period_count_ff  <= period_count_in;
         pair_first_ff    <= pair_first_in;
         pair_low_ff      <= pair_low_in;
         rsp_valid_ff     <= rsp_valid_in;
         // Result payload loads with each accepted item and holds while stalled.
         if (req_accept) begin
            miso_byte_ff  <= miso_byte_in;
            miso_valid_ff <= miso_valid_in;
            done_ff       <= done_in;
            reset_seen_ff <= reset_seen_in;
            error_ff      <= error_in;
         end
      end
   end

endmodule

`default_nettype wire

/* tb/sv/tb_spi_adc_command_interface.sv */
`timescale 1ns / 100ps

// Testbench for the serial converter command interface.
//
// A queue of pending items is filled by the stimulus process. A clocked driver
// presents them on req_ch with random gaps. At every accepted transfer, it runs
// the item through the local behavioral model of the interface and queues the
// result that the block must return. A clocked monitor takes results from rsp_ch
// under random stalls and compares each one, field by field, with the oldest
// queued expectation. The configuration registers are written only while nothing
// is in flight.
module tb_spi_adc_command_interface;

   // Generous bound on the whole run, in cycles. Each item may wait on a random
   // gap before it is sent and on a random stall before its result is taken.
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_ITEMS = 205;

   // Command decoder phases of the local model.
   typedef enum logic [2:0] {
      PH_COMMAND     = 3'd0,
      PH_MODE_HIGH   = 3'd1,
      PH_MODE_LOW    = 3'd2,
      PH_CONT_FIRST  = 3'd3,
      PH_CONT_SECOND = 3'd4
   } link_phase_type;

   typedef struct packed {
      logic        is_tick;
      logic [7:0]  mosi;
      logic [15:0] sample;
      logic        drain;   // hold this item back until every result has come
   } adc_item_type;

   typedef struct packed {
      logic [7:0]         miso_byte;
      logic               miso_valid;
      logic               ready_n;
      logic               conversion_done;
      logic               reset_seen;
      sac_pkg::error_type error_code;
   } adc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sac_req_if req_ch ();
   sac_rsp_if rsp_ch ();
   sac_csr_if csr_ch ();

   spi_adc_command_interface uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   adc_item_type   pending_items[$];
   adc_result_type expected_results[$];

   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic        drain_next = 1'b0;

   // ---------------------------------------------------------------------------
   // Behavioral model of the interface: configuration and command state.
   // ---------------------------------------------------------------------------
   logic [23:0] cfg_start_delay;
   logic [23:0] cfg_conv_period;

   logic [7:0]     adc_status;
   logic [15:0]    adc_mode;
   logic [15:0]    adc_data;
   logic [31:0]    adc_history;
   link_phase_type adc_phase;
   logic [15:0]    adc_tx_bytes;
   logic [1:0]     adc_tx_left;
   logic [7:0]     adc_mode_high;
   logic [23:0]    adc_start_count;
   logic           adc_start_armed;
   logic [2:0]     adc_start_mode;
   logic           adc_streaming;
   logic [23:0]    adc_period_count;
   logic [7:0]     adc_pair_first;
   logic [7:0]     adc_pair_low;

   // Register reset, as done by thirty-two ones or by an idle start. The phase
   // and any armed start are not touched here.
   task automatic clear_adc_regs();
      adc_status       = 8'h80;
      adc_mode         = sac_pkg::MODE_RESET;
      adc_data         = 16'h0000;
      adc_streaming    = 1'b0;
      adc_period_count = 24'd0;
      adc_history      = 32'd0;
   endtask

   task automatic reset_model();
      cfg_start_delay = sac_pkg::STARTUP_DELAY_RESET;
      cfg_conv_period = sac_pkg::CONV_PERIOD_RESET;
      clear_adc_regs();
      adc_phase       = PH_COMMAND;
      adc_tx_bytes    = 16'h0000;
      adc_tx_left     = 2'd0;
      adc_mode_high   = 8'h00;
      adc_start_count = 24'd0;
      adc_start_armed = 1'b0;
      adc_start_mode  = 3'd0;
      adc_pair_first  = 8'h00;
      adc_pair_low    = 8'h00;
   endtask

   // Shifts one byte into the history. Reports whether the history became all
   // ones, in which case the registers have been reset.
   task automatic shift_history(input logic [7:0] b, output logic hit);
      adc_history = {adc_history[23:0], b};
      hit = (adc_history == sac_pkg::HISTORY_ALL_ONES);
      if (hit) clear_adc_regs();
   endtask

   // A conversion result lands in the data word and the ready bit goes low.
   task automatic latch_sample(input logic [15:0] s);
      adc_data      = s;
      adc_status[7] = 1'b0;
   endtask

   // Applies one accepted item to the model and returns the result it causes.
   task automatic decode_item(input adc_item_type it, output adc_result_type res);
      logic fired;
      logic hit;
      res = '0;
      res.error_code = sac_pkg::ERR_NONE;
      if (it.is_tick) begin
         fired = 1'b0;
         // An armed start counts down first; zero delay behaves as one tick.
         if (adc_start_armed) begin
            if (adc_start_count <= 24'd1) begin
               fired           = 1'b1;
               adc_start_armed = 1'b0;
               adc_start_count = 24'd0;
               case (adc_start_mode)
                  sac_pkg::MODE_CONTINUOUS: begin
                     latch_sample(it.sample);
                     res.conversion_done = 1'b1;
                     adc_streaming       = 1'b1;
                     adc_period_count    = cfg_conv_period;
                  end
                  sac_pkg::MODE_SINGLE: begin
                     adc_streaming       = 1'b0;
                     adc_period_count    = 24'd0;
                     latch_sample(it.sample);
                     res.conversion_done = 1'b1;
                  end
                  sac_pkg::MODE_IDLE: begin
                     clear_adc_regs();
                  end
                  default: begin
                     res.error_code = sac_pkg::ERR_BAD_MODE;
                  end
               endcase
            end else begin
               adc_start_count = adc_start_count - 24'd1;
            end
         end
         // A start that fires wins the tick over the periodic conversion.
         if (!fired && adc_streaming) begin
            if (adc_period_count <= 24'd1) begin
               latch_sample(it.sample);
               res.conversion_done = 1'b1;
               adc_period_count    = cfg_conv_period;
            end else begin
               adc_period_count = adc_period_count - 24'd1;
            end
         end
      end else if (adc_tx_left != 2'd0) begin
         // Response byte pending: the incoming byte is a dummy.
         res.miso_byte  = adc_tx_bytes[15:8];
         res.miso_valid = 1'b1;
         adc_tx_bytes   = {adc_tx_bytes[7:0], 8'h00};
         adc_tx_left    = adc_tx_left - 2'd1;
      end else if (adc_phase == PH_MODE_HIGH) begin
         adc_mode_high = it.mosi;
         adc_phase     = PH_MODE_LOW;
      end else if (adc_phase == PH_MODE_LOW) begin
         adc_mode        = {adc_mode_high, it.mosi};
         adc_start_mode  = adc_mode[sac_pkg::MODE_SHIFT +: 3];
         adc_start_armed = 1'b1;
         adc_start_count = cfg_start_delay;
         adc_phase       = PH_COMMAND;
      end else if (adc_phase == PH_CONT_FIRST) begin
         res.miso_byte  = adc_data[15:8];
         res.miso_valid = 1'b1;
         adc_pair_low   = adc_data[7:0];
         adc_pair_first = it.mosi;
         adc_phase      = PH_CONT_SECOND;
      end else if (adc_phase == PH_CONT_SECOND) begin
         res.miso_byte  = adc_pair_low;
         res.miso_valid = 1'b1;
         adc_status[7]  = 1'b1;
         adc_phase      = PH_CONT_FIRST;
         if (adc_pair_first == sac_pkg::CMD_READ_DATA ||
             it.mosi == sac_pkg::CMD_READ_DATA) begin
            adc_phase = PH_COMMAND;
         end else begin
            shift_history(adc_pair_first, hit);
            if (!hit) shift_history(it.mosi, hit);
            if (hit) begin
               res.reset_seen = 1'b1;
               adc_phase      = PH_COMMAND;
            end
         end
      end else begin
         shift_history(it.mosi, hit);
         res.reset_seen = hit;
         case (it.mosi)
            sac_pkg::CMD_READ_ID: begin
               adc_tx_bytes = {sac_pkg::CHIP_ID, 8'h00};
               adc_tx_left  = 2'd1;
            end
            sac_pkg::CMD_READ_MODE: begin
               adc_tx_bytes = adc_mode;
               adc_tx_left  = 2'd2;
            end
            sac_pkg::CMD_WRITE_MODE: begin
               adc_phase = PH_MODE_HIGH;
            end
            sac_pkg::CMD_READ_STATUS: begin
               adc_tx_bytes = {adc_status, 8'h00};
               adc_tx_left  = 2'd1;
            end
            sac_pkg::CMD_READ_DATA: begin
               // Nothing is sent while no new conversion is waiting.
               if (!adc_status[7]) begin
                  adc_tx_bytes  = adc_data;
                  adc_tx_left   = 2'd2;
                  adc_status[7] = 1'b1;
               end
            end
            sac_pkg::CMD_READ_CONT: begin
               adc_status[7] = 1'b1;
               adc_phase     = PH_CONT_FIRST;
            end
            sac_pkg::CMD_NOP: begin
            end
            default: begin
               res.error_code = sac_pkg::ERR_BAD_CMD;
            end
         endcase
      end
      res.ready_n = adc_status[7];
   endtask

   // ---------------------------------------------------------------------------
   // Mismatch reporting.
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("result %0d: %s, got 0x%0h, expected 0x%0h", results_seen, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_result();
      adc_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected", 16'(rsp_ch.miso_byte), 16'h0);
         return;
      end
      want = expected_results.pop_front();
      check_field("miso_byte", 16'(rsp_ch.miso_byte), 16'(want.miso_byte));
      check_field("miso_valid", 16'(rsp_ch.miso_valid), 16'(want.miso_valid));
      check_field("ready_n", 16'(rsp_ch.ready_n), 16'(want.ready_n));
      check_field("conversion_done", 16'(rsp_ch.conversion_done),
                  16'(want.conversion_done));
      check_field("reset_seen", 16'(rsp_ch.reset_seen), 16'(want.reset_seen));
      check_field("error_code", 16'(rsp_ch.error_code), 16'(want.error_code));
   endtask

   // ---------------------------------------------------------------------------
   // Driver. At each edge it first records a transfer that has just happened,
   // then decides what to present next. Each item draws its own random gap; now
   // and then a stretch with no gaps at all is toggled. An item marked for
   // draining waits until the monitor has taken every result.
   // ---------------------------------------------------------------------------
   adc_item_type   item_on_bus;
   adc_result_type predicted;
   int unsigned    send_gap = 0;
   logic           send_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decode_item(item_on_bus, predicted);
            expected_results.push_back(predicted);
            items_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && items_sent != results_seen)) begin
               item_on_bus = pending_items.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.req_type     <= item_on_bus.is_tick;
               req_ch.mosi_byte    <= item_on_bus.mosi;
               req_ch.sample_value <= item_on_bus.sample;
               if ($urandom_range(0, 99) < 4) send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 5);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor. The results counter is updated with a nonblocking assignment so
   // that the driver's drain test sees the same value whatever the order of the
   // two blocks at an edge. After each transfer the receiver draws a stall.
   // ---------------------------------------------------------------------------
   int unsigned recv_stall = 0;
   logic        recv_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result();
            results_seen <= results_seen + 1;
            if ($urandom_range(0, 99) < 4) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 5);
         end
         if (recv_stall != 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_spi_adc_command_interface: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] b);
      adc_item_type it;
      it.is_tick = 1'b0;
      it.mosi    = b;
      it.sample  = 16'($urandom_range(0, 65535));
      it.drain   = drain_next;
      drain_next = 1'b0;
      pending_items.push_back(it);
   endtask

   task automatic put_tick(input logic [15:0] s);
      adc_item_type it;
      it.is_tick = 1'b1;
      it.mosi    = 8'($urandom_range(0, 255));
      it.sample  = s;
      it.drain   = drain_next;
      drain_next = 1'b0;
      pending_items.push_back(it);
   endtask

   // Idle means: nothing queued, nothing presented and every result taken.
   // It is tested at the falling edge, when all updates of the edge are settled.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || items_sent != results_seen);
   endtask

   task automatic write_register(input sac_pkg::csr_index_type idx,
                                 input logic [23:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == sac_pkg::CSR_STARTUP_DELAY) cfg_start_delay = value;
      else cfg_conv_period = value;
   endtask

   task automatic configure(input logic [23:0] delay, input logic [23:0] period);
      wait_until_idle();
      write_register(sac_pkg::CSR_STARTUP_DELAY, delay);
      write_register(sac_pkg::CSR_CONV_PERIOD, period);
      wait_until_idle();
   endtask

   // Bytes inside a continuous read that do not end it.
   function automatic logic [7:0] stream_byte();
      logic [7:0] b;
      b = ($urandom_range(0, 9) == 0) ? sac_pkg::CMD_NOP : 8'($urandom_range(0, 255));
      if (b == sac_pkg::CMD_READ_DATA) b = b ^ 8'h01;
      return b;
   endfunction

   // Ticks now and then fall between the bytes of a command sequence.
   task automatic maybe_tick();
      if ($urandom_range(0, 4) == 0) put_tick(16'($urandom_range(0, 65535)));
   endtask

   // One random sequence. Most are well-formed commands with random contents,
   // so that mode writes, conversions and continuous reads are reached often;
   // the rest is noise.
   task automatic put_random_sequence();
      int unsigned pick;
      int unsigned n;
      logic [2:0]  mode;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         n = $urandom_range(1, 10);
         repeat (n) put_tick(16'($urandom_range(0, 65535)));
      end else if (pick < 46) begin
         n = $urandom_range(0, 99);
         if (n < 30) mode = sac_pkg::MODE_CONTINUOUS;
         else if (n < 55) mode = sac_pkg::MODE_SINGLE;
         else if (n < 75) mode = sac_pkg::MODE_IDLE;
         else mode = 3'($urandom_range(3, 7));
         put_byte(sac_pkg::CMD_WRITE_MODE);
         maybe_tick();
         put_byte({mode, 5'($urandom_range(0, 31))});
         maybe_tick();
         put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 54) begin
         // Whether data goes out depends on the ready bit; two NOP bytes are
         // harmless dummies either way.
         put_byte(sac_pkg::CMD_READ_DATA);
         maybe_tick();
         put_byte(sac_pkg::CMD_NOP);
         put_byte(sac_pkg::CMD_NOP);
      end else if (pick < 62) begin
         put_byte($urandom_range(0, 1) ? sac_pkg::CMD_READ_ID : sac_pkg::CMD_READ_STATUS);
         maybe_tick();
         put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 67) begin
         put_byte(sac_pkg::CMD_READ_MODE);
         put_byte(8'($urandom_range(0, 255)));
         maybe_tick();
         put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 79) begin
         put_byte(sac_pkg::CMD_READ_CONT);
         n = $urandom_range(0, 5);
         repeat (n) begin
            maybe_tick();
            put_byte(stream_byte());
            maybe_tick();
            put_byte(stream_byte());
         end
         // The read-data byte ends the stream from either half of a pair.
         if ($urandom_range(0, 1)) begin
            put_byte(sac_pkg::CMD_READ_DATA);
            put_byte(8'($urandom_range(0, 255)));
         end else begin
            put_byte(stream_byte());
            put_byte(sac_pkg::CMD_READ_DATA);
         end
         put_byte(sac_pkg::CMD_NOP);
         put_byte(sac_pkg::CMD_NOP);
      end else if (pick < 84) begin
         repeat (4) put_byte(sac_pkg::CMD_NOP);
      end else if (pick < 88) begin
         drain_next = 1'b1;
      end else begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
            else put_tick(16'($urandom_range(0, 65535)));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------
   logic [23:0] phase_delay[7];
   logic [23:0] phase_period[7];

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.req_type     = 1'b0;
      req_ch.mosi_byte    = 8'h00;
      req_ch.sample_value = 16'h0000;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = sac_pkg::CSR_STARTUP_DELAY;
      csr_ch.data         = 24'd0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with short timing so that starts fire within a few ticks.
      configure(24'd2, 24'd3);
      put_byte(sac_pkg::CMD_READ_ID);      put_byte(8'h00);
      put_byte(sac_pkg::CMD_READ_STATUS);  put_byte(8'hFF);
      put_byte(sac_pkg::CMD_READ_MODE);    put_byte(8'h55);  put_byte(8'hAA);
      put_byte(sac_pkg::CMD_READ_DATA);    // not ready: nothing is sent
      put_byte(8'h13);                     // unknown command
      put_byte(sac_pkg::CMD_NOP);
      // Single conversion; it completes on the second tick. The sender first
      // waits until every earlier result has come back.
      drain_next = 1'b1;
      put_byte(sac_pkg::CMD_WRITE_MODE);
      put_byte({sac_pkg::MODE_SINGLE, 5'd0});
      put_byte(8'h00);
      put_tick(16'h0000);                  put_tick(16'h1234);
      put_byte(sac_pkg::CMD_READ_DATA);    put_byte(8'h00);  put_byte(8'h00);
      // Continuous conversion, then a continuous read ended by read data.
      put_byte(sac_pkg::CMD_WRITE_MODE);
      put_byte({sac_pkg::MODE_CONTINUOUS, 5'd0});
      put_byte(8'h00);
      put_tick(16'h0000);                  put_tick(16'hFFFF);
      put_byte(sac_pkg::CMD_READ_CONT);    put_byte(8'h11);
      put_byte(sac_pkg::CMD_READ_DATA);
      // Unsupported mode raises an error when its start fires.
      put_byte(sac_pkg::CMD_WRITE_MODE);   put_byte(8'hE0);  put_byte(8'hFF);
      put_tick(16'h0001);                  put_tick(16'h8000);
      // Thirty-two ones reset the registers.
      repeat (4) put_byte(sac_pkg::CMD_NOP);

      // Random part over several register settings, the extremes among them.
      // Zero behaves as one tick; the largest delay never runs out here.
      phase_delay[0] = 24'd1;               phase_period[0] = 24'd1;
      phase_delay[1] = 24'd0;               phase_period[1] = 24'd0;
      phase_delay[2] = 24'hFFFFFF;          phase_period[2] = 24'd3;
      phase_delay[3] = 24'd4;               phase_period[3] = 24'hFFFFFF;
      phase_delay[4] = 24'($urandom_range(1, 12));
      phase_period[4] = 24'($urandom_range(1, 10));
      phase_delay[5] = 24'($urandom_range(1, 30));
      phase_period[5] = 24'($urandom_range(2, 20));
      phase_delay[6] = 24'd2;               phase_period[6] = 24'd5;

      for (int p = 0; p < 7; p++) begin
         configure(phase_delay[p], phase_period[p]);
         while (pending_items.size() < PHASE_ITEMS) put_random_sequence();
      end

      // Drain, then watch the outputs for anything unexpected before the final check.
      wait_until_idle();
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", 16'h0, 16'(expected_results.size()));
      if (error_count == 0) begin
         $display("tb_spi_adc_command_interface: PASS");
      end else begin
         $display("tb_spi_adc_command_interface: FAIL");
      end
      $finish;
   end

endmodule
